// File: hw/rtl/rbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants for the ray versus box slab test unit.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int FIELD_W   = 32;  // width of coordinate and bound fields
   localparam int EPS_W     = 16;  // width of the exit epsilon register
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_AXES  = 3;
   localparam int NUM_SLABS = 2 * NUM_AXES;
   localparam int FRAC_BITS = 16;
   localparam int QUO_BITS  = 31;  // quotient magnitude bits below saturation
   localparam int SAT_SHIFT = QUO_BITS - FRAC_BITS;
   localparam int T_W       = 32;  // signed slab parameter width

   localparam logic signed [T_W-1:0] T_SAT = {1'b0, {(T_W-1){1'b1}}};

   localparam logic [FIELD_W-1:0] BOUND_MIN_RST = 32'hFFFF_0000;
   localparam logic [FIELD_W-1:0] BOUND_MAX_RST = 32'h0001_0000;
   localparam logic [EPS_W-1:0]   EPS_RST       = 16'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_MIN_X    = 3'd0,
      CSR_BOX_MAX_X    = 3'd1,
      CSR_BOX_MIN_Y    = 3'd2,
      CSR_BOX_MAX_Y    = 3'd3,
      CSR_BOX_MIN_Z    = 3'd4,
      CSR_BOX_MAX_Z    = 3'd5,
      CSR_EXIT_EPSILON = 3'd6
   } csr_index_type;

   // Per-slab control that rides along with the quotient.
   typedef struct packed {
      logic sat;  // quotient is at or above the saturation limit
      logic neg;  // slab parameter is negative
   } slab_ctl_type;

endpackage

// File: hw/rtl/rbst_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_req_if / rbst_rsp_if
// Valid/ready channels for ray requests and test results.
// ----------------------------------------------------------------------------
interface rbst_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [rbst_pkg::FIELD_W-1:0] origin_x;
   logic signed [rbst_pkg::FIELD_W-1:0] origin_y;
   logic signed [rbst_pkg::FIELD_W-1:0] origin_z;
   logic signed [rbst_pkg::FIELD_W-1:0] dir_x;
   logic signed [rbst_pkg::FIELD_W-1:0] dir_y;
   logic signed [rbst_pkg::FIELD_W-1:0] dir_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   output ready);
endinterface

interface rbst_rsp_if;
   logic valid;
   logic ready;
   logic box_hit;
   logic origin_inside;

   modport source (output valid, box_hit, origin_inside, input ready);
   modport sink   (input valid, box_hit, origin_inside, output ready);
endinterface

// File: hw/rtl/rbst_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_prep
// Three front stages: slab numerators with bound swap, magnitudes and
// signs, then the saturation check ahead of the divider.
// ----------------------------------------------------------------------------
module rbst_prep #(
   parameter int CW = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [rbst_pkg::FIELD_W-1:0] origin   [rbst_pkg::NUM_AXES],
   input  logic [rbst_pkg::FIELD_W-1:0] dir      [rbst_pkg::NUM_AXES],
   input  logic [rbst_pkg::FIELD_W-1:0] bound_lo [rbst_pkg::NUM_AXES],
   input  logic [rbst_pkg::FIELD_W-1:0] bound_hi [rbst_pkg::NUM_AXES],
   output logic                         out_valid,
   output logic [CW-1:0]                n_mag    [rbst_pkg::NUM_SLABS],
   output logic [CW-1:0]                d_mag    [rbst_pkg::NUM_SLABS],
   output rbst_pkg::slab_ctl_type       ctl      [rbst_pkg::NUM_SLABS],
   output logic                         org_in_box
);
   import rbst_pkg::*;

   logic signed [CW-1:0] lo_v [NUM_AXES];
   logic signed [CW-1:0] hi_v [NUM_AXES];
   logic signed [CW-1:0] o_v  [NUM_AXES];
   logic signed [CW-1:0] d_v  [NUM_AXES];
   logic signed [CW:0]   a_v  [NUM_AXES];
   logic signed [CW:0]   b_v  [NUM_AXES];

   logic signed [CW:0]   s1_num_in [NUM_SLABS];
   logic                 s1_box_in;
   logic signed [CW:0]   s1_num_ff [NUM_SLABS];
   logic signed [CW-1:0] s1_dir_ff [NUM_AXES];
   logic                 s1_box_ff;
   logic                 s1_valid_ff;

   logic [CW-1:0]        s2_n_in   [NUM_SLABS];
   logic [CW-1:0]        s2_d_in   [NUM_AXES];
   logic                 s2_neg_in [NUM_SLABS];
   logic [CW-1:0]        s2_n_ff   [NUM_SLABS];
   logic [CW-1:0]        s2_d_ff   [NUM_AXES];
   logic                 s2_neg_ff [NUM_SLABS];
   logic                 s2_box_ff;
   logic                 s2_valid_ff;

   logic                 s3_sat_in [NUM_SLABS];
   logic [CW-1:0]        s3_n_ff   [NUM_SLABS];
   logic [CW-1:0]        s3_d_ff   [NUM_SLABS];
   slab_ctl_type         s3_ctl_ff [NUM_SLABS];
   logic                 s3_box_ff;
   logic                 s3_valid_ff;

   // Stage 1: differences to both bounds; entry and exit trade places
   // when the direction is negative.
   always_comb begin
      s1_box_in = 1'b1;
      for (int k = 0; k < NUM_AXES; k++) begin
         lo_v[k] = $signed(CW'(bound_lo[k]));
         hi_v[k] = $signed(CW'(bound_hi[k]));
         o_v[k]  = $signed(CW'(origin[k]));
         d_v[k]  = $signed(CW'(dir[k]));
         a_v[k]  = {lo_v[k][CW-1], lo_v[k]} - {o_v[k][CW-1], o_v[k]};
         b_v[k]  = {hi_v[k][CW-1], hi_v[k]} - {o_v[k][CW-1], o_v[k]};
         s1_num_in[2*k]   = d_v[k][CW-1] ? b_v[k] : a_v[k];
         s1_num_in[2*k+1] = d_v[k][CW-1] ? a_v[k] : b_v[k];
         if (!((o_v[k] > lo_v[k]) && (o_v[k] < hi_v[k]))) begin
            s1_box_in = 1'b0;
         end
      end
   end

   // Stage 2: magnitudes and the sign of each quotient.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         s2_d_in[k] = CW'(s1_dir_ff[k][CW-1] ? -s1_dir_ff[k] : s1_dir_ff[k]);
         s2_n_in[2*k]     = CW'(s1_num_ff[2*k][CW] ? -s1_num_ff[2*k] : s1_num_ff[2*k]);
         s2_n_in[2*k+1]   = CW'(s1_num_ff[2*k+1][CW] ? -s1_num_ff[2*k+1]
                                                      : s1_num_ff[2*k+1]);
         s2_neg_in[2*k]   = s1_num_ff[2*k][CW] ^ s1_dir_ff[k][CW-1];
         s2_neg_in[2*k+1] = s1_num_ff[2*k+1][CW] ^ s1_dir_ff[k][CW-1];
      end
   end

   // Stage 3: the quotient saturates when n * 2^16 >= d * 2^31. A zero
   // direction with a nonzero numerator lands here too; a zero numerator
   // always gives zero.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         for (int s = 0; s < 2; s++) begin
            s3_sat_in[2*k+s] = (s2_n_ff[2*k+s] != '0) &&
               ((CW+SAT_SHIFT)'(s2_n_ff[2*k+s]) >= {s2_d_ff[k], {SAT_SHIFT{1'b0}}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_num_ff <= s1_num_in;
         s1_dir_ff <= d_v;
         s1_box_ff <= s1_box_in;
         s2_n_ff   <= s2_n_in;
         s2_d_ff   <= s2_d_in;
         s2_neg_ff <= s2_neg_in;
         s2_box_ff <= s1_box_ff;
         s3_box_ff <= s2_box_ff;
         for (int j = 0; j < NUM_SLABS; j++) begin
            s3_n_ff[j]       <= s2_n_ff[j];
            s3_ctl_ff[j].sat <= s3_sat_in[j];
            s3_ctl_ff[j].neg <= s2_neg_ff[j];
         end
         for (int k = 0; k < NUM_AXES; k++) begin
            s3_d_ff[2*k]   <= s2_d_ff[k];
            s3_d_ff[2*k+1] <= s2_d_ff[k];
         end
      end
   end

   assign out_valid  = s3_valid_ff;
   assign n_mag      = s3_n_ff;
   assign d_mag      = s3_d_ff;
   assign ctl        = s3_ctl_ff;
   assign org_in_box = s3_box_ff;

endmodule

// File: hw/rtl/rbst_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_div_pipe
// Six-lane restoring divider, one quotient bit per stage, followed by a
// stage that applies saturation and sign to form the slab parameters.
// ----------------------------------------------------------------------------
module rbst_div_pipe #(
   parameter int CW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [CW-1:0]                 n_mag  [rbst_pkg::NUM_SLABS],
   input  logic [CW-1:0]                 d_mag  [rbst_pkg::NUM_SLABS],
   input  rbst_pkg::slab_ctl_type        ctl    [rbst_pkg::NUM_SLABS],
   input  logic                          in_box,
   output logic                          out_valid,
   output logic signed [rbst_pkg::T_W-1:0] t_val [rbst_pkg::NUM_SLABS],
   output logic                          out_box
);
   import rbst_pkg::*;

   localparam int RW = CW + QUO_BITS;

   logic [RW-1:0]       r_ff   [QUO_BITS][NUM_SLABS];
   logic [QUO_BITS-1:0] q_ff   [QUO_BITS][NUM_SLABS];
   logic [CW-1:0]       d_ff   [QUO_BITS][NUM_SLABS];
   slab_ctl_type        ctl_ff [QUO_BITS][NUM_SLABS];
   logic                box_ff [QUO_BITS];
   logic                v_ff   [QUO_BITS];

   logic signed [T_W-1:0] mag_v [NUM_SLABS];
   logic signed [T_W-1:0] t_in  [NUM_SLABS];
   logic signed [T_W-1:0] t_ff  [NUM_SLABS];
   logic                  tv_ff;
   logic                  tbox_ff;

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
      localparam int BIT = QUO_BITS - 1 - s;

      logic [RW-1:0]       r_src   [NUM_SLABS];
      logic [QUO_BITS-1:0] q_src   [NUM_SLABS];
      logic [CW-1:0]       d_src   [NUM_SLABS];
      slab_ctl_type        ctl_src [NUM_SLABS];
      logic                box_src;
      logic                v_src;
      logic [RW-1:0]       dsh     [NUM_SLABS];
      logic [RW-1:0]       r_in    [NUM_SLABS];
      logic [QUO_BITS-1:0] q_in    [NUM_SLABS];

      if (s == 0) begin : g_first
         always_comb begin
            for (int j = 0; j < NUM_SLABS; j++) begin
               r_src[j]   = RW'(n_mag[j]) << FRAC_BITS;
               q_src[j]   = '0;
               d_src[j]   = d_mag[j];
               ctl_src[j] = ctl[j];
            end
            box_src = in_box;
            v_src   = in_valid;
         end
      end else begin : g_next
         always_comb begin
            r_src   = r_ff[s-1];
            q_src   = q_ff[s-1];
            d_src   = d_ff[s-1];
            ctl_src = ctl_ff[s-1];
            box_src = box_ff[s-1];
            v_src   = v_ff[s-1];
         end
      end

      // A zero divisor sets no quotient bits, so a zero numerator over a
      // zero direction comes out as zero.
      always_comb begin
         for (int j = 0; j < NUM_SLABS; j++) begin
            dsh[j]  = RW'(d_src[j]) << BIT;
            q_in[j] = q_src[j];
            if ((d_src[j] != '0) && (r_src[j] >= dsh[j])) begin
               r_in[j]      = r_src[j] - dsh[j];
               q_in[j][BIT] = 1'b1;
            end else begin
               r_in[j] = r_src[j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= r_in;
            q_ff[s]   <= q_in;
            d_ff[s]   <= d_src;
            ctl_ff[s] <= ctl_src;
            box_ff[s] <= box_src;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_SLABS; j++) begin
         mag_v[j] = ctl_ff[QUO_BITS-1][j].sat ? T_SAT
                                              : $signed({1'b0, q_ff[QUO_BITS-1][j]});
         t_in[j]  = ctl_ff[QUO_BITS-1][j].neg ? -mag_v[j] : mag_v[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else if (en) begin
         tv_ff <= v_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t_in;
         tbox_ff <= box_ff[QUO_BITS-1];
      end
   end

   assign out_valid = tv_ff;
   assign t_val     = t_ff;
   assign out_box   = tbox_ff;

endmodule

// File: hw/rtl/rbst_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_reduce
// Largest entry and smallest exit over the three axes, then the hit test.
// ----------------------------------------------------------------------------
module rbst_reduce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [rbst_pkg::T_W-1:0] t_val [rbst_pkg::NUM_SLABS],
   input  logic                            in_box,
   input  logic [rbst_pkg::EPS_W-1:0]      exit_eps,
   output logic                            out_valid,
   output logic                            box_hit,
   output logic                            out_box
);
   import rbst_pkg::*;

   logic signed [T_W-1:0] t0_in;
   logic signed [T_W-1:0] t1_in;
   logic signed [T_W-1:0] t0_ff;
   logic signed [T_W-1:0] t1_ff;
   logic                  r1_box_ff;
   logic                  r1_valid_ff;
   logic                  hit_in;
   logic                  hit_ff;
   logic                  r2_box_ff;
   logic                  r2_valid_ff;

   // Entry parameters sit in even slabs, exit parameters in odd ones.
   always_comb begin
      t0_in = t_val[0];
      t1_in = t_val[1];
      for (int k = 1; k < NUM_AXES; k++) begin
         if (t_val[2*k] > t0_in) begin
            t0_in = t_val[2*k];
         end
         if (t_val[2*k+1] < t1_in) begin
            t1_in = t_val[2*k+1];
         end
      end
   end

   assign hit_in = (t0_ff < t1_ff) && (t1_ff > $signed(T_W'(exit_eps)));

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
      end else if (en) begin
         r1_valid_ff <= in_valid;
         r2_valid_ff <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff     <= t0_in;
         t1_ff     <= t1_in;
         r1_box_ff <= in_box;
         hit_ff    <= hit_in;
         r2_box_ff <= r1_box_ff;
      end
   end

   assign out_valid = r2_valid_ff;
   assign box_hit   = hit_ff;
   assign out_box   = r2_box_ff;

endmodule

// File: hw/rtl/ray_box_slab_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Tests a stream of rays against an axis-aligned box held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_chan carries one ray: origin and direction in signed
//   Q16.16. Each request yields exactly one result on rsp_chan: box_hit and
//   origin_inside. The box bounds and exit epsilon are written through the
//   csr_ port (index 0..6, one write per cycle) while no request is in
//   flight; after reset the box spans -1.0 to 1.0 on each axis and the
//   epsilon is 7.
//   Throughput is one request per cycle while the skid register is empty.
//   A result passes through three setup stages, 31 divider stages (one
//   quotient bit each), a saturation and sign stage, two reduction stages
//   and the output register before it appears on rsp_chan.
//   Reset empties the pipeline; configuration returns to its reset values.
//   When the receiver stalls, one more result moves into a skid register
//   and then the whole pipeline holds; req_chan.ready is a register output
//   and drops only while the skid register is full.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   rbst_req_if.sink                        req_chan,
   rbst_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [rbst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbst_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import rbst_pkg::*;

   logic [FIELD_W-1:0] bound_ff [NUM_SLABS];
   logic [EPS_W-1:0]   eps_ff;

   logic               pipe_en;
   logic [FIELD_W-1:0] origin_v [NUM_AXES];
   logic [FIELD_W-1:0] dir_v    [NUM_AXES];
   logic [FIELD_W-1:0] lo_v     [NUM_AXES];
   logic [FIELD_W-1:0] hi_v     [NUM_AXES];

   logic                  prep_valid;
   logic [COORD_WIDTH-1:0] prep_n [NUM_SLABS];
   logic [COORD_WIDTH-1:0] prep_d [NUM_SLABS];
   slab_ctl_type          prep_ctl [NUM_SLABS];
   logic                  prep_box;

   logic                  div_valid;
   logic signed [T_W-1:0] div_t [NUM_SLABS];
   logic                  div_box;

   logic                  red_valid;
   logic                  red_hit;
   logic                  red_box;
   logic                  red_push;

   logic out_valid_ff, out_valid_in;
   logic out_hit_ff, out_hit_in;
   logic out_box_ff, out_box_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_hit_ff, skid_hit_in;
   logic skid_box_ff, skid_box_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            bound_ff[2*k]   <= BOUND_MIN_RST;
            bound_ff[2*k+1] <= BOUND_MAX_RST;
         end
         eps_ff <= EPS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BOX_MIN_X:    bound_ff[0] <= csr_write_data;
            CSR_BOX_MAX_X:    bound_ff[1] <= csr_write_data;
            CSR_BOX_MIN_Y:    bound_ff[2] <= csr_write_data;
            CSR_BOX_MAX_Y:    bound_ff[3] <= csr_write_data;
            CSR_BOX_MIN_Z:    bound_ff[4] <= csr_write_data;
            CSR_BOX_MAX_Z:    bound_ff[5] <= csr_write_data;
            CSR_EXIT_EPSILON: eps_ff      <= csr_write_data[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves as a whole; it holds only while the skid is full.
   assign pipe_en        = !skid_valid_ff;
   assign req_chan.ready = pipe_en;

   always_comb begin
      origin_v[0] = req_chan.origin_x;
      origin_v[1] = req_chan.origin_y;
      origin_v[2] = req_chan.origin_z;
      dir_v[0]    = req_chan.dir_x;
      dir_v[1]    = req_chan.dir_y;
      dir_v[2]    = req_chan.dir_z;
      for (int k = 0; k < NUM_AXES; k++) begin
         lo_v[k] = bound_ff[2*k];
         hi_v[k] = bound_ff[2*k+1];
      end
   end

   rbst_prep #(
      .CW (COORD_WIDTH)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (req_chan.valid),
      .origin     (origin_v),
      .dir        (dir_v),
      .bound_lo   (lo_v),
      .bound_hi   (hi_v),
      .out_valid  (prep_valid),
      .n_mag      (prep_n),
      .d_mag      (prep_d),
      .ctl        (prep_ctl),
      .org_in_box (prep_box)
   );

   rbst_div_pipe #(
      .CW (COORD_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (prep_valid),
      .n_mag     (prep_n),
      .d_mag     (prep_d),
      .ctl       (prep_ctl),
      .in_box    (prep_box),
      .out_valid (div_valid),
      .t_val     (div_t),
      .out_box   (div_box)
   );

   rbst_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (div_valid),
      .t_val     (div_t),
      .in_box    (div_box),
      .exit_eps  (eps_ff),
      .out_valid (red_valid),
      .box_hit   (red_hit),
      .out_box   (red_box)
   );

   // Output register with a one-entry skid behind it.
   assign red_push = red_valid && pipe_en;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_hit_in    = out_hit_ff;
      out_box_in    = out_box_ff;
      skid_valid_in = skid_valid_ff;
      skid_hit_in   = skid_hit_ff;
      skid_box_in   = skid_box_ff;
      if (!out_valid_ff || rsp_chan.ready) begin
         out_valid_in  = skid_valid_ff || red_push;
         out_hit_in    = skid_valid_ff ? skid_hit_ff : red_hit;
         out_box_in    = skid_valid_ff ? skid_box_ff : red_box;
         skid_valid_in = 1'b0;
      end else if (red_push) begin
         skid_valid_in = 1'b1;
         skid_hit_in   = red_hit;
         skid_box_in   = red_box;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hit_ff  <= out_hit_in;
      out_box_ff  <= out_box_in;
      skid_hit_ff <= skid_hit_in;
      skid_box_ff <= skid_box_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.box_hit       = out_hit_ff;
   assign rsp_chan.origin_inside = out_box_ff;

   // The skid register holds a result only behind a waiting output.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // A result leaving the pipeline into a stalled output lands in the skid.
   a_stall_fills_skid : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready && red_push) |=> skid_valid_ff)
      else $error("result lost while output stalled");

   // Once the receiver takes a result, the skid result moves into the output register and the skid empties.
   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_chan.ready) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid register did not drain");

endmodule
